### hw/rtl/bbf_pkg.sv
// ----------------------------------------------------------------------------
// bbf_pkg
// Shared types and constants of the bollinger band filter: port widths,
// register indexes and reset values, controller states, command and status.
// ----------------------------------------------------------------------------
`default_nettype none

package bbf_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int MID_W      = 24;
    localparam int BAND_W     = 33;
    localparam int WL_W       = 7;
    localparam int BW_W       = 16;
    localparam int LL_W       = 2 * WL_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 96;
    localparam int OUT_USER_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_WIDTH    = 8'd1;

    localparam logic [WL_W-1:0] WL_RESET = 7'd20;
    localparam logic [BW_W-1:0] BW_RESET = 16'd512;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_PREP,
        ST_SQMEAN,
        ST_VARSTART,
        ST_DIVIDE,
        ST_ROOT,
        ST_SCALE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic square;
        logic accum;
        logic prep;
        logic sq_mean;
        logic var_start;
        logic root_start;
        logic scale;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic warm;
        logic div_busy;
        logic root_busy;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

### hw/rtl/bbf_divu.sv
// ----------------------------------------------------------------------------
// bbf_divu
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bbf_divu #(
    parameter int N_W = 60,
    parameter int D_W = 14
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_dividend,
    input  wire logic [D_W-1:0] i_divisor,
    output logic                o_busy,
    output logic [N_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   r_quo, n_quo;
    logic [D_W-1:0]   r_rem, n_rem;
    logic [D_W-1:0]   r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [D_W:0]     w_trial;
    logic [D_W:0]     w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_quo[N_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_rem = w_ge ? w_diff[D_W-1:0] : w_trial[D_W-1:0];
        n_quo = {r_quo[N_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(N_W);
        end else if (r_busy) begin
            r_busy <= r_cnt != CNT_W'(1);
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### hw/rtl/bbf_isqrt.sv
// ----------------------------------------------------------------------------
// bbf_isqrt
// Floor integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bbf_isqrt #(
    parameter int R_W = 30
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [2*R_W-1:0] i_value,
    output logic                  o_busy,
    output logic [R_W-1:0]        o_root
);

    localparam int CNT_W = $clog2(R_W + 1);

    logic [2*R_W-1:0] r_val;
    logic [R_W:0]     r_rem;
    logic [R_W-1:0]   r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [R_W+2:0]   w_rem2;
    logic [R_W+2:0]   w_trial;
    logic [R_W+2:0]   w_diff;
    logic             w_ge;

    assign w_rem2  = {r_rem, r_val[2*R_W-1 -: 2]};
    assign w_trial = (R_W+3)'({r_root, 2'b01});
    assign w_ge    = w_rem2 >= w_trial;
    assign w_diff  = w_rem2 - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(R_W);
        end else if (r_busy) begin
            r_busy <= r_cnt != CNT_W'(1);
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[2*R_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[R_W:0] : w_rem2[R_W:0];
            r_root <= {r_root[R_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

`default_nettype wire

### hw/rtl/bbf_datapath.sv
// ----------------------------------------------------------------------------
// bbf_datapath
// Sample ring, running sums, products, dividers, square root and the
// output register of the band filter.
// ----------------------------------------------------------------------------
`default_nettype none

module bbf_datapath
    import bbf_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    input  wire logic [SAMPLE_W-1:0]   i_sample,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [MID_W-1:0]           o_middle,
    output logic [BAND_W-1:0]          o_upper,
    output logic [BAND_W-1:0]          o_lower,
    output logic                       o_warm
);

    localparam int SB     = SAMPLE_BITS;
    localparam int PW     = $clog2(WINDOW_MAX);
    localparam int IXW    = 9;
    localparam int SUM_W  = SB + PW + 1;
    localparam int ABS_W  = SUM_W - 1;
    localparam int SQ_W   = 2 * SB - 1 + PW;
    localparam int LP_W   = SQ_W + WL_W;
    localparam int NUM_W  = (LP_W > 2 * ABS_W) ? LP_W : 2 * ABS_W;
    localparam int R_W    = (NUM_W + 1) / 2;
    localparam int DEVP_W = BW_W + R_W;
    localparam int DEV_W  = DEVP_W - 8;
    localparam int EXT_W  = (DEV_W + 1 > BAND_W + 1) ? DEV_W + 1 : BAND_W + 1;

    // configuration
    logic [WL_W-1:0] r_wl;
    logic [BW_W-1:0] r_bw;
    logic            w_clear;
    logic [WL_W-1:0] w_len;

    assign w_clear = i_cfg_valid && (i_cfg_index == CFG_WINDOW_LENGTH);

    always_comb begin
        if (r_wl == '0) begin
            w_len = WL_W'(1);
        end else if (IXW'(r_wl) > IXW'(WINDOW_MAX)) begin
            w_len = WL_W'(WINDOW_MAX);
        end else begin
            w_len = r_wl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl <= WL_RESET;
            r_bw <= BW_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW_LENGTH: r_wl <= i_cfg_data[WL_W-1:0];
                CFG_BAND_WIDTH:    r_bw <= i_cfg_data[BW_W-1:0];
                default: ;
            endcase
        end
    end

    // ring pointer and fill
    logic [PW-1:0]   r_wp;
    logic [WL_W-1:0] r_fill;
    logic [PW-1:0]   w_wp_eff;
    logic [PW-1:0]   n_wp;
    logic [WL_W-1:0] n_fill;
    logic            w_evict;
    logic            r_evict;
    logic            r_warm;

    assign w_wp_eff = (IXW'(r_wp) >= IXW'(w_len)) ? '0 : r_wp;
    assign n_wp     = (IXW'(w_wp_eff) + IXW'(1) >= IXW'(w_len)) ? '0 : w_wp_eff + PW'(1);
    assign w_evict  = r_fill >= w_len;
    assign n_fill   = w_evict ? w_len : r_fill + WL_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (w_clear) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (i_cmd.accept) begin
            r_wp   <= n_wp;
            r_fill <= n_fill;
        end
    end

    // sample ring, read before write
    logic signed [SB-1:0] mem_ring [WINDOW_MAX];
    logic signed [SB-1:0] r_old;
    logic signed [SB-1:0] r_x;
    logic signed [SB-1:0] w_x;

    assign w_x = i_sample[SB-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_old              <= mem_ring[w_wp_eff];
            mem_ring[w_wp_eff] <= w_x;
        end
    end

    // squares and running sums
    logic signed [2*SB-1:0] w_xsq;
    logic signed [2*SB-1:0] w_oldsq;
    logic [2*SB-1:0]        r_xsq;
    logic [2*SB-1:0]        r_oldsq;
    logic signed [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]         r_sqsum;
    logic signed [SUM_W-1:0] w_old_ext;
    logic signed [SUM_W-1:0] w_sub1;
    logic [SQ_W-1:0]         w_sub2;

    assign w_xsq     = w_x * w_x;
    assign w_oldsq   = r_old * r_old;
    assign w_old_ext = SUM_W'(r_old);
    assign w_sub1    = r_evict ? w_old_ext : '0;
    assign w_sub2    = r_evict ? SQ_W'(r_oldsq) : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x     <= w_x;
            r_xsq   <= unsigned'(w_xsq);
            r_evict <= w_evict;
            r_warm  <= n_fill >= w_len;
        end
        if (i_cmd.square) begin
            r_oldsq <= unsigned'(w_oldsq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_sqsum <= '0;
        end else if (w_clear) begin
            r_sum   <= '0;
            r_sqsum <= '0;
        end else if (i_cmd.accum) begin
            r_sum   <= r_sum - w_sub1 + SUM_W'(r_x);
            r_sqsum <= r_sqsum - w_sub2 + SQ_W'(r_xsq);
        end
    end

    // variance numerator
    logic signed [SUM_W-1:0] w_neg_sum;
    logic [ABS_W-1:0]        r_abs;
    logic                    r_neg;
    logic [LP_W-1:0]         r_lprod;
    logic [LL_W-1:0]         r_ll;
    logic [2*ABS_W-1:0]      r_sq1;
    logic [NUM_W-1:0]        w_lp_ext;
    logic [NUM_W-1:0]        w_sq1_ext;
    logic [NUM_W-1:0]        w_num;
    logic [LP_W-1:0]         w_lprod;
    logic [LL_W-1:0]         w_ll;
    logic [2*ABS_W-1:0]      w_sq1;

    assign w_neg_sum = -r_sum;
    assign w_lprod   = r_sqsum * w_len;
    assign w_ll      = w_len * w_len;
    assign w_sq1     = r_abs * r_abs;
    assign w_lp_ext  = NUM_W'(r_lprod);
    assign w_sq1_ext = NUM_W'(r_sq1);
    assign w_num     = (w_lp_ext >= w_sq1_ext) ? w_lp_ext - w_sq1_ext : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_abs   <= r_sum[SUM_W-1] ? w_neg_sum[ABS_W-1:0] : r_sum[ABS_W-1:0];
            r_neg   <= r_sum[SUM_W-1];
            r_lprod <= w_lprod;
            r_ll    <= w_ll;
        end
        if (i_cmd.sq_mean) begin
            r_sq1 <= w_sq1;
        end
    end

    // dividers and square root
    logic             w_mean_busy;
    logic             w_var_busy;
    logic             w_root_busy;
    logic [ABS_W-1:0] w_mean_q;
    logic [NUM_W-1:0] w_var_q;
    logic [R_W-1:0]   w_root;
    logic [ABS_W-1:0] w_mean_neg;
    logic signed [SB-1:0] r_mean;

    bbf_divu #(
        .N_W (ABS_W),
        .D_W (WL_W)
    ) u_mean_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sq_mean),
        .i_dividend (r_abs),
        .i_divisor  (w_len),
        .o_busy     (w_mean_busy),
        .o_quotient (w_mean_q)
    );

    bbf_divu #(
        .N_W (NUM_W),
        .D_W (LL_W)
    ) u_var_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.var_start),
        .i_dividend (w_num),
        .i_divisor  (r_ll),
        .o_busy     (w_var_busy),
        .o_quotient (w_var_q)
    );

    bbf_isqrt #(
        .R_W (R_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.root_start),
        .i_value ((2*R_W)'(w_var_q)),
        .o_busy  (w_root_busy),
        .o_root  (w_root)
    );

    assign w_mean_neg = -w_mean_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_start) begin
            r_mean <= r_neg ? w_mean_neg[SB-1:0] : w_mean_q[SB-1:0];
        end
    end

    // band offset and output register
    logic [DEVP_W-1:0]       r_devp;
    logic signed [EXT_W-1:0] w_mean_ext;
    logic signed [EXT_W-1:0] w_dev_ext;
    logic signed [EXT_W-1:0] w_up;
    logic signed [EXT_W-1:0] w_lo;
    logic                    r_out_valid;
    logic [MID_W-1:0]        r_mid;
    logic [BAND_W-1:0]       r_up;
    logic [BAND_W-1:0]       r_lo;
    logic                    r_warm_out;
    logic                    w_out_free;

    assign w_mean_ext = EXT_W'(r_mean);
    assign w_dev_ext  = signed'(EXT_W'(r_devp[DEVP_W-1:8]));
    assign w_up       = w_mean_ext + w_dev_ext;
    assign w_lo       = w_mean_ext - w_dev_ext;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_devp <= r_bw * w_root;
        end
        if (i_cmd.emit) begin
            r_mid      <= r_warm ? MID_W'(r_mean) : '0;
            r_up       <= r_warm ? w_up[BAND_W-1:0] : '0;
            r_lo       <= r_warm ? w_lo[BAND_W-1:0] : '0;
            r_warm_out <= r_warm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.warm      = r_warm;
    assign o_status.div_busy  = w_mean_busy || w_var_busy;
    assign o_status.root_busy = w_root_busy;
    assign o_status.out_free  = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_middle    = r_mid;
    assign o_upper     = r_up;
    assign o_lower     = r_lo;
    assign o_warm      = r_warm_out;

    a_fill_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_len)
        else $error("fill count beyond window length");

    a_wp_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        IXW'(r_wp) < IXW'(w_len))
        else $error("write pointer beyond window length");

endmodule

`default_nettype wire

### hw/rtl/bbf_ctrl.sv
// ----------------------------------------------------------------------------
// bbf_ctrl
// Sequencer of the band filter: steps one item through update, division,
// square root and output; before the window is full it goes from update to output.
// ----------------------------------------------------------------------------
`default_nettype none

module bbf_ctrl
    import bbf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_in_valid) n_state = ST_SQUARE;
            ST_SQUARE:   n_state = ST_ACCUM;
            ST_ACCUM:    n_state = i_status.warm ? ST_PREP : ST_EMIT;
            ST_PREP:     n_state = ST_SQMEAN;
            ST_SQMEAN:   n_state = ST_VARSTART;
            ST_VARSTART: n_state = ST_DIVIDE;
            ST_DIVIDE:   if (!i_status.div_busy) n_state = ST_ROOT;
            ST_ROOT:     if (!i_status.root_busy) n_state = ST_SCALE;
            ST_SCALE:    n_state = ST_EMIT;
            ST_EMIT:     if (i_status.out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_SQUARE:   o_cmd.square    = 1'b1;
            ST_ACCUM:    o_cmd.accum     = 1'b1;
            ST_PREP:     o_cmd.prep      = 1'b1;
            ST_SQMEAN:   o_cmd.sq_mean   = 1'b1;
            ST_VARSTART: o_cmd.var_start = 1'b1;
            ST_DIVIDE:   o_cmd.root_start = !i_status.div_busy;
            ST_ROOT:     ;
            ST_SCALE:    o_cmd.scale     = 1'b1;
            ST_EMIT:     o_cmd.emit      = i_status.out_free;
            default:     ;
        endcase
    end

    a_idle_units_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !(i_status.div_busy || i_status.root_busy))
        else $error("arithmetic unit busy while idle");

    a_emit_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && i_status.out_free) |=> r_state == ST_IDLE)
        else $error("item not released after output load");

    a_divide_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.var_start |=> i_status.div_busy)
        else $error("divider not busy after start");

endmodule

`default_nettype wire

### hw/rtl/bollinger_band_filter_core.sv
// ----------------------------------------------------------------------------
// bollinger_band_filter_core
// Moving-window mean and standard-deviation bands over a price stream.
// ----------------------------------------------------------------------------
// items: a new sample is taken only in the idle state, after the last item has
//   been loaded into the output register; warm-up items skip division and root
// the time per item is set by the bit-serial variance division followed by
//   the bit-serial square root
// reset: synchronous active low, window emptied, registers to 20 and 512;
//   ring contents are not cleared and no clearing pass runs
`default_nettype none

module bollinger_band_filter_core
    import bbf_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [SAMPLE_W-1:0]   i_s_axis_tdata,   // sample
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,   // middle_band, high_band, low_band
    output logic [OUT_USER_W-1:0]      o_m_axis_tuser,   // warm
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd              w_cmd;
    t_status           w_status;
    logic [MID_W-1:0]  w_middle;
    logic [BAND_W-1:0] w_upper;
    logic [BAND_W-1:0] w_lower;
    logic              w_warm;

    bbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    bbf_datapath #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_sample    (i_s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_middle    (w_middle),
        .o_upper     (w_upper),
        .o_lower     (w_lower),
        .o_warm      (w_warm)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = OUT_DATA_W'({w_lower, w_upper, w_middle});
    assign o_m_axis_tuser = w_warm;

endmodule

`default_nettype wire
